// ===== rtl/csv_fst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared types, constants and helper functions of the field splitter.
// ----------------------------------------------------------------------------
package csv_fst_pkg;

	localparam int unsigned MAX_LEN    = 4096;
	localparam int unsigned OFS_W      = $clog2(MAX_LEN + 1);
	localparam int unsigned FIELD_W    = 13;
	localparam int unsigned OUT_DATA_W = 32;

	typedef logic [OFS_W-1:0] ofs_t;

	localparam ofs_t OFS_MAX = ofs_t'(MAX_LEN);

	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] DELIM_RESET = 8'h2C;

	typedef enum logic {
		REQ_DATA = 1'b0,
		REQ_EOR  = 1'b1
	} req_t;

	typedef struct packed {
		req_t       req;
		logic [7:0] char_byte;
	} item_t;

	typedef struct packed {
		logic               present;
		logic [FIELD_W-1:0] start_ofs;
		logic [FIELD_W-1:0] end_ofs;
		logic               empty;
		logic               last;
		logic               ovf;
	} result_t;

	function automatic logic is_trimmed(logic [7:0] b);
		return b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_QUOTE};
	endfunction

	function automatic ofs_t sat_inc(ofs_t v);
		return (v >= OFS_MAX) ? OFS_MAX : v + ofs_t'(1);
	endfunction

	function automatic logic [FIELD_W-1:0] to_field(ofs_t v);
		return FIELD_W'(v);
	endfunction

endpackage

// ===== rtl/csv_fst_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter parser
// Holds the record state and the delimiter register, and forms the result
// of the item in the input register in the same cycle.
// ----------------------------------------------------------------------------
module csv_fst_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  csv_fst_pkg::item_t    item,
	input  logic                  take,
	output logic                  res_valid,
	output csv_fst_pkg::result_t  res
);
	import csv_fst_pkg::*;

	logic [7:0] delim_q;
	ofs_t       pos_q;
	ofs_t       raw_begin_q;
	ofs_t       kept_begin_q;
	ofs_t       kept_finish_q;
	logic       kept_seen_q;
	logic       quote_odd_q;
	logic       prev_bs_q;
	logic       ovf_q;
	logic       raw_seen_q;

	ofs_t       off;
	ofs_t       off_inc;
	logic       ovf_next;
	logic       quote_next;
	logic       close;
	logic       is_eor;
	ofs_t       emit_start;
	ofs_t       emit_end;

	assign is_eor     = (item.req == REQ_EOR);
	assign off        = (pos_q >= OFS_MAX) ? OFS_MAX : pos_q;
	assign off_inc    = sat_inc(off);
	assign ovf_next   = ovf_q | (pos_q >= OFS_MAX);
	assign quote_next = quote_odd_q ^ ((item.char_byte == CH_QUOTE) & ~prev_bs_q);
	assign close      = ~is_eor & (item.char_byte == delim_q) & ~quote_next;
	assign emit_start = kept_seen_q ? kept_begin_q : raw_begin_q;
	assign emit_end   = kept_seen_q ? kept_finish_q : raw_begin_q;

	assign res_valid = is_eor | close;

	always_comb begin
		res.present   = 1'b1;
		res.start_ofs = to_field(emit_start);
		res.end_ofs   = to_field(emit_end);
		res.empty     = ~kept_seen_q;
		res.last      = is_eor;
		res.ovf       = is_eor ? ovf_q : ovf_next;
		// A record end with nothing after the last delimiter is a bare marker.
		if (is_eor && !raw_seen_q) begin
			res.present   = 1'b0;
			res.start_ofs = '0;
			res.end_ofs   = '0;
			res.empty     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_we) begin
			delim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			raw_begin_q   <= '0;
			kept_begin_q  <= '0;
			kept_finish_q <= '0;
			kept_seen_q   <= 1'b0;
			quote_odd_q   <= 1'b0;
			prev_bs_q     <= 1'b0;
			ovf_q         <= 1'b0;
			raw_seen_q    <= 1'b0;
		end else if (take) begin
			if (is_eor) begin
				pos_q         <= '0;
				raw_begin_q   <= '0;
				kept_begin_q  <= '0;
				kept_finish_q <= '0;
				kept_seen_q   <= 1'b0;
				quote_odd_q   <= 1'b0;
				prev_bs_q     <= 1'b0;
				ovf_q         <= 1'b0;
				raw_seen_q    <= 1'b0;
			end else begin
				pos_q       <= sat_inc(pos_q);
				ovf_q       <= ovf_next;
				quote_odd_q <= quote_next;
				prev_bs_q   <= (item.char_byte == CH_BSLASH);
				if (close) begin
					raw_begin_q   <= off_inc;
					kept_begin_q  <= '0;
					kept_finish_q <= '0;
					kept_seen_q   <= 1'b0;
					raw_seen_q    <= 1'b0;
				end else begin
					raw_seen_q <= 1'b1;
					if (!is_trimmed(item.char_byte)) begin
						if (!kept_seen_q) begin
							kept_begin_q <= off;
						end
						kept_seen_q   <= 1'b1;
						kept_finish_q <= off_inc;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/csv_fst_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter output register
// Holds one result beat for the master side until the receiver takes it.
// ----------------------------------------------------------------------------
module csv_fst_out_reg (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  csv_fst_pkg::result_t                   res,
	output logic                                   can_load,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [csv_fst_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                   m_tuser,
	output logic                                   m_tlast
);
	import csv_fst_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign can_load = ~valid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.present;
	assign m_tlast  = res_q.last;
	assign m_tdata  = OUT_DATA_W'({res_q.ovf, res_q.empty, res_q.end_ofs, res_q.start_ofs});

endmodule

// ===== rtl/csv_field_splitter_trim.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSV field splitter with trimming
// Splits a byte stream of records into fields and reports trimmed offsets.
// ----------------------------------------------------------------------------
// Each slave beat carries one record byte in s_tdata, with s_tuser low, or an
// end-of-record marker with s_tuser high. A master beat is sent for each
// delimiter that closes a field and for each end of record. The cfg port
// writes the delimiter byte; the user must use it only while the block is
// idle, which the block itself does not enforce. An accepted beat is held in
// the input register, where the parser updates the record state and forms
// the result; the result is then loaded into the output register, from which
// it is offered to the receiver.
// One beat is accepted every cycle unless a result-bearing beat is stalled:
// the path from the input register through the parser to the output register
// carries one item per clock. When the receiver stalls, the output register
// holds its beat, the input register holds the next one, and s_tready falls
// only when a result-bearing beat in the input register cannot move on. Data
// bytes that give no result keep flowing. Reset clears the valid flags of both
// registers and the record state, and sets the delimiter to a comma.
// ----------------------------------------------------------------------------
module csv_field_splitter_trim (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [7:0]                          cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // char_byte
	input  logic                                s_tuser,  // req_type
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// field_start[12:0], field_end[25:13], field_empty[26], overflow[27], zero
	output logic [csv_fst_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                                m_tuser,  // field_present
	output logic                                m_tlast   // record_end
);
	import csv_fst_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid;
	result_t res;
	logic    can_load;
	logic    advance;

	assign advance  = valid_s1 & (~res_valid | can_load);
	assign s_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{req: req_t'(s_tuser), char_byte: s_tdata};
		end
	end

	csv_fst_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item_s1),
		.take      (advance),
		.res_valid (res_valid),
		.res       (res)
	);

	csv_fst_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance & res_valid),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A held item in the input register must not be replaced.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register item lost while stalled");

	// A bare record-end marker carries zero offsets and always ends a record.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata[26:0] == 27'd0))
		else $error("bare marker with field contents");

	// An empty field reports equal start and end offsets.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && m_tdata[26] |-> (m_tdata[12:0] == m_tdata[25:13]))
		else $error("empty field with differing offsets");

	// Field offsets never run backward.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata[12:0] <= m_tdata[25:13]))
		else $error("field start beyond field end");

endmodule
